FILE: design/kps_pkg.sv
package kps_pkg;

  // Scan machine phases
  typedef enum logic [3:0] {
    PH_UP       = 4'b0001,
    PH_DEBOUNCE = 4'b0010,
    PH_START    = 4'b0100,
    PH_REPEAT   = 4'b1000
  } scan_phase_t;

  // Command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Register indexes
  localparam logic [7:0] REG_SHIFT_ONE    = 8'd0;
  localparam logic [7:0] REG_SHIFT_TWO    = 8'd1;
  localparam logic [7:0] REG_REPEAT_START = 8'd2;
  localparam logic [7:0] REG_REPEAT       = 8'd3;

  // Register reset values
  localparam logic [7:0] SHIFT_ONE_RST    = 8'd4;
  localparam logic [7:0] SHIFT_TWO_RST    = 8'd8;
  localparam logic [7:0] REPEAT_START_RST = 8'd50;
  localparam logic [7:0] REPEAT_RST       = 8'd10;

  // Code returned when nothing was popped
  localparam logic [7:0] EMPTY_CODE = 8'hFF;

  // Operation passed from the scan front to the code store
  typedef struct packed {
    logic       is_read;
    logic       push;
    logic [7:0] code;
  } scan_op_t;

endpackage

FILE: design/kps_ram.sv
module kps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/kps_front.sv
module kps_front #(
  parameter int NUM_ROWS = 2,
  parameter int NUM_COLS = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration writes
  input  logic                         cfg_valid,
  input  logic [7:0]                   cfg_index,
  input  logic [7:0]                   cfg_data,
  // incoming words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [NUM_ROWS*NUM_COLS-1:0] key_matrix,
  input  logic [1:0]                   shift_keys,
  // classified operations
  output logic                         op_valid,
  input  logic                         op_ready,
  output kps_pkg::scan_op_t            op
);

  localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

  logic [7:0] shift_one_offset;
  logic [7:0] shift_two_offset;
  logic [7:0] repeat_start_ticks;
  logic [7:0] repeat_ticks;

  kps_pkg::scan_phase_t phase, phase_next;
  logic [7:0] start_counter, start_counter_next;
  logic [7:0] repeat_counter, repeat_counter_next;

  logic          fire;
  logic          down;
  logic          push;
  logic [RW-1:0] row_idx;
  logic [CW-1:0] col_idx;
  logic [NUM_COLS-1:0] row_bits;
  logic [7:0]    code;

  assign in_ready = op_ready;
  assign fire     = in_valid && op_ready;
  assign down     = |key_matrix;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_one_offset   <= kps_pkg::SHIFT_ONE_RST;
      shift_two_offset   <= kps_pkg::SHIFT_TWO_RST;
      repeat_start_ticks <= kps_pkg::REPEAT_START_RST;
      repeat_ticks       <= kps_pkg::REPEAT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kps_pkg::REG_SHIFT_ONE:    shift_one_offset   <= cfg_data;
        kps_pkg::REG_SHIFT_TWO:    shift_two_offset   <= cfg_data;
        kps_pkg::REG_REPEAT_START: repeat_start_ticks <= cfg_data;
        kps_pkg::REG_REPEAT:       repeat_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Priority decode: first pressed row, then lowest pressed column, plus held shift offsets
  always_comb begin
    row_idx = '0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (|key_matrix[r*NUM_COLS +: NUM_COLS]) begin
        row_idx = RW'(r);
      end
    end
    row_bits = key_matrix[row_idx*NUM_COLS +: NUM_COLS];
    col_idx = '0;
    for (int c = NUM_COLS - 1; c >= 0; c--) begin
      if (row_bits[c]) begin
        col_idx = CW'(c);
      end
    end
    code = 8'(row_idx) * 8'(NUM_COLS) + 8'(col_idx);
    if (shift_keys[0]) begin
      code = code + shift_one_offset;
    end
    if (shift_keys[1]) begin
      code = code + shift_two_offset;
    end
  end

  // Debounce and auto-repeat machine
  always_comb begin
    phase_next          = phase;
    start_counter_next  = start_counter;
    repeat_counter_next = repeat_counter;
    push                = 1'b0;
    case (phase)
      kps_pkg::PH_UP: begin
        if (down) phase_next = kps_pkg::PH_DEBOUNCE;
      end
      kps_pkg::PH_DEBOUNCE: begin
        if (down) begin
          push               = 1'b1;
          start_counter_next = repeat_start_ticks;
          phase_next         = kps_pkg::PH_START;
        end else begin
          phase_next = kps_pkg::PH_UP;
        end
      end
      kps_pkg::PH_START: begin
        if (!down) begin
          phase_next = kps_pkg::PH_DEBOUNCE;
        end else if (start_counter != 8'd0) begin
          start_counter_next = start_counter - 8'd1;
          if (start_counter == 8'd1) begin
            push                = 1'b1;
            repeat_counter_next = repeat_ticks;
            phase_next          = kps_pkg::PH_REPEAT;
          end
        end
      end
      kps_pkg::PH_REPEAT: begin
        if (!down) begin
          phase_next = kps_pkg::PH_DEBOUNCE;
        end else if (repeat_counter != 8'd0) begin
          repeat_counter_next = repeat_counter - 8'd1;
          if (repeat_counter == 8'd1) begin
            push                = 1'b1;
            repeat_counter_next = repeat_ticks;
          end
        end
      end
      default: phase_next = kps_pkg::PH_UP;
    endcase
  end

  // Advance the machine on scan ticks only
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= kps_pkg::PH_UP;
      start_counter  <= 8'd0;
      repeat_counter <= 8'd0;
    end else if (fire && command == kps_pkg::CMD_TICK) begin
      phase          <= phase_next;
      start_counter  <= start_counter_next;
      repeat_counter <= repeat_counter_next;
    end
  end

  // Hand the classified word to the queue
  assign op_valid   = in_valid;
  assign op.is_read = (command == kps_pkg::CMD_READ);
  assign op.push    = (command == kps_pkg::CMD_TICK) && push;
  assign op.code    = code;

endmodule

FILE: design/kps_queue.sv
module kps_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kps_pkg::scan_op_t in_op,
  output logic              out_valid,
  input  logic              out_ready,
  output kps_pkg::scan_op_t out_op
);

  kps_pkg::scan_op_t slot0, slot1;
  logic [1:0]        count;
  logic              push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_op    = slot0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Shift the two slots toward the head
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= in_op;
      end
      if (push && count == 2'd2) begin
        slot1 <= in_op;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= in_op;
      end else begin
        slot1 <= in_op;
      end
    end
  end

endmodule

FILE: design/kps_back.sv
module kps_back #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  input  kps_pkg::scan_op_t op,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        key_code,
  output logic              key_valid,
  output logic              key_pending,
  output logic [4:0]        pending_count
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count, count_next;
  logic          fire, pop_ok, push_ok;
  logic [7:0]    rdata;
  logic          from_store;
  logic          pending;
  logic [4:0]    count_out;

  assign op_ready = !out_valid || out_ready;
  assign fire     = op_valid && op_ready;
  assign pop_ok   = op.is_read && (count != '0);
  assign push_ok  = op.push && (count != NW'(FIFO_DEPTH));

  always_comb begin
    count_next = count;
    if (push_ok) count_next = count + NW'(1);
    if (pop_ok)  count_next = count - NW'(1);
  end

  kps_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (fire && push_ok),
    .waddr(wr_ptr),
    .wdata(op.code),
    .re   (fire && pop_ok),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else if (fire) begin
      count <= count_next;
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      from_store <= pop_ok;
      pending    <= (count_next != '0);
      count_out  <= 5'(count_next);
    end
  end

  assign key_code      = from_store ? rdata : kps_pkg::EMPTY_CODE;
  assign key_valid     = from_store;
  assign key_pending   = pending;
  assign pending_count = count_out;

endmodule

FILE: design/keypad_scanner_with_repeat_top.sv
// Path: an accepted input word goes through the queue, then the output register.
// Throughput: one word per cycle; a two-entry queue between the scan front
// and the code store, plus the output register, lets either side stall alone.
// Reset (rst, synchronous): scan machine to up, counters and pointers to zero,
// registers to their defaults; the code store itself is not cleared.
module keypad_scanner_with_repeat_top #(
  parameter int NUM_ROWS   = 2,
  parameter int NUM_COLS   = 2,
  parameter int FIFO_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  // command, key_matrix, shift_keys (from bit 0 up), zero padded
  input  logic [((NUM_ROWS*NUM_COLS+3+7)/8)*8-1:0] s_tdata,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // key_code, key_valid, key_pending, pending_count (from bit 0 up), zero padded
  output logic [15:0] m_tdata
);

  localparam int M = NUM_ROWS * NUM_COLS;

  logic              f_valid, f_ready;
  kps_pkg::scan_op_t f_op;
  logic              b_valid, b_ready;
  kps_pkg::scan_op_t b_op;
  logic [7:0]        key_code;
  logic              key_valid, key_pending;
  logic [4:0]        pending_count;

  assign cfg_ready = 1'b1;

  kps_front #(
    .NUM_ROWS(NUM_ROWS),
    .NUM_COLS(NUM_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .command   (s_tdata[0]),
    .key_matrix(s_tdata[M:1]),
    .shift_keys(s_tdata[M+2:M+1]),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op        (f_op)
  );

  kps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_op    (f_op),
    .out_valid(b_valid),
    .out_ready(b_ready),
    .out_op   (b_op)
  );

  kps_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (b_valid),
    .op_ready     (b_ready),
    .op           (b_op),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .key_code     (key_code),
    .key_valid    (key_valid),
    .key_pending  (key_pending),
    .pending_count(pending_count)
  );

  assign m_tdata = {1'b0, pending_count, key_pending, key_valid, key_code};

endmodule

FILE: tb/kps_checker.sv
`timescale 1ns / 1ps

module kps_checker #(
  parameter int NUM_ROWS   = 2,
  parameter int NUM_COLS   = 2,
  parameter int FIFO_DEPTH = 16,
  parameter int DATA_W     = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [15:0]       m_tdata,
  output int                fail_count,
  output int                results_due
);

  localparam int KEYS = NUM_ROWS * NUM_COLS;

  typedef struct {
    logic [7:0] key_code;
    logic       key_valid;
    logic       key_pending;
    logic [4:0] pending_count;
  } key_result_t;

  // Shadow registers
  logic [7:0] shift_one;
  logic [7:0] shift_two;
  logic [7:0] repeat_start;
  logic [7:0] repeat_ival;

  // Shadow scanner and code store
  kps_pkg::scan_phase_t phase;
  logic [7:0]  start_cnt;
  logic [7:0]  repeat_cnt;
  logic [7:0]  code_fifo [FIFO_DEPTH];
  int          wr_ptr;
  int          rd_ptr;
  int          held;

  key_result_t expected_results [$];

  // First pressed row, lowest pressed column in it, plus held shift offsets
  function automatic logic [7:0] key_code_of(input logic [KEYS-1:0] matrix,
                                             input logic [1:0] shifts);
    int         row;
    int         col;
    logic [7:0] code;
    row = NUM_ROWS;
    col = NUM_COLS;
    for (int r = NUM_ROWS - 1; r >= 0; r--)
      for (int c = NUM_COLS - 1; c >= 0; c--)
        if (matrix[r*NUM_COLS + c]) begin
          row = r;
          col = c;
        end
    code = 8'(col + row * NUM_COLS);
    if (shifts[0]) code = code + shift_one;
    if (shifts[1]) code = code + shift_two;
    return code;
  endfunction

  // Drop the code silently when the store is full
  task automatic store_code(input logic [7:0] code);
    if (held < FIFO_DEPTH) begin
      code_fifo[wr_ptr] = code;
      wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
      held++;
    end
  endtask

  // Advance the debounce / auto-repeat machine by one scan tick
  task automatic advance_scan(input logic [KEYS-1:0] matrix, input logic [1:0] shifts);
    logic down;
    down = |matrix;
    case (phase)
      kps_pkg::PH_UP: begin
        if (down) phase = kps_pkg::PH_DEBOUNCE;
      end
      kps_pkg::PH_DEBOUNCE: begin
        if (down) begin
          store_code(key_code_of(matrix, shifts));
          start_cnt = repeat_start;
          phase = kps_pkg::PH_START;
        end else begin
          phase = kps_pkg::PH_UP;
        end
      end
      kps_pkg::PH_START: begin
        if (!down) begin
          phase = kps_pkg::PH_DEBOUNCE;
        end else if (start_cnt != 0) begin
          start_cnt--;
          if (start_cnt == 0) begin
            store_code(key_code_of(matrix, shifts));
            repeat_cnt = repeat_ival;
            phase = kps_pkg::PH_REPEAT;
          end
        end
      end
      default: begin
        if (!down) begin
          phase = kps_pkg::PH_DEBOUNCE;
        end else if (repeat_cnt != 0) begin
          repeat_cnt--;
          if (repeat_cnt == 0) begin
            store_code(key_code_of(matrix, shifts));
            repeat_cnt = repeat_ival;
          end
        end
      end
    endcase
  endtask

  // Work out the result word for one accepted input word
  task automatic scan_word(input logic [DATA_W-1:0] word, output key_result_t res);
    logic [KEYS-1:0] matrix;
    logic [1:0]      shifts;
    matrix = word[KEYS:1];
    shifts = word[KEYS+2 -: 2];
    res.key_code  = kps_pkg::EMPTY_CODE;
    res.key_valid = 1'b0;
    if (word[0] == kps_pkg::CMD_READ) begin
      if (held != 0) begin
        res.key_code  = code_fifo[rd_ptr];
        res.key_valid = 1'b1;
        rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
        held--;
      end
    end else begin
      advance_scan(matrix, shifts);
    end
    res.key_pending   = (held != 0);
    res.pending_count = 5'(held);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    key_result_t due;
    key_result_t made;
    if (rst) begin
      shift_one    = kps_pkg::SHIFT_ONE_RST;
      shift_two    = kps_pkg::SHIFT_TWO_RST;
      repeat_start = kps_pkg::REPEAT_START_RST;
      repeat_ival  = kps_pkg::REPEAT_RST;
      phase        = kps_pkg::PH_UP;
      start_cnt    = '0;
      repeat_cnt   = '0;
      wr_ptr       = 0;
      rd_ptr       = 0;
      held         = 0;
      expected_results.delete();
    end else begin
      // Compare a result word with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result word %h arrived with none due", $time, m_tdata);
          fail_count++;
        end else begin
          due = expected_results.pop_front();
          check_field("key_code", due.key_code, m_tdata[7:0]);
          check_field("key_valid", 8'(due.key_valid), 8'(m_tdata[8]));
          check_field("key_pending", 8'(due.key_pending), 8'(m_tdata[9]));
          check_field("pending_count", 8'(due.pending_count), 8'(m_tdata[14:10]));
        end
      end
      // Mirror register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kps_pkg::REG_SHIFT_ONE:    shift_one    = cfg_data;
          kps_pkg::REG_SHIFT_TWO:    shift_two    = cfg_data;
          kps_pkg::REG_REPEAT_START: repeat_start = cfg_data;
          kps_pkg::REG_REPEAT:       repeat_ival  = cfg_data;
          default: ;
        endcase
      end
      // Predict the result of each accepted input word
      if (s_tvalid && s_tready) begin
        scan_word(s_tdata, made);
        expected_results.push_back(made);
      end
    end
    results_due <= expected_results.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int NUM_ROWS    = 2;
  localparam int NUM_COLS    = 2;
  localparam int FIFO_DEPTH  = 16;
  localparam int KEYS        = NUM_ROWS * NUM_COLS;
  localparam int DATA_W      = ((KEYS + 3 + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 100;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_index;
  logic [7:0]        cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;

  int fail_count;
  int results_due;
  int words_sent = 0;
  int burst_left = 0;
  bit steady     = 1'b0;
  bit hold_req   = 1'b0;

  keypad_scanner_with_repeat_top #(
    .NUM_ROWS  (NUM_ROWS),
    .NUM_COLS  (NUM_COLS),
    .FIFO_DEPTH(FIFO_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  kps_checker #(
    .NUM_ROWS  (NUM_ROWS),
    .NUM_COLS  (NUM_COLS),
    .FIFO_DEPTH(FIFO_DEPTH),
    .DATA_W    (DATA_W)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word; idle between bursts unless a steady stream is wanted
  task automatic send_word(input logic cmd, input logic [KEYS-1:0] matrix,
                           input logic [1:0] shifts);
    logic [DATA_W-1:0] word;
    int                gap;
    word = '0;
    word[0] = cmd;
    word[KEYS:1] = matrix;
    word[KEYS+2 -: 2] = shifts;
    if (!steady && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    words_sent++;
  endtask

  task automatic tick(input logic [KEYS-1:0] matrix, input logic [1:0] shifts);
    send_word(kps_pkg::CMD_TICK, matrix, shifts);
  endtask

  // Matrix and shift fields are don't-care on a read, so randomize them
  task automatic read_key();
    logic [KEYS-1:0] matrix;
    logic [1:0]      shifts;
    matrix = KEYS'($urandom);
    shifts = 2'($urandom);
    send_word(kps_pkg::CMD_READ, matrix, shifts);
  endtask

  // Stop offering and wait until every predicted word has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic put_reg(input logic [7:0] idx, input logic [7:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_settings(input logic [7:0] one, input logic [7:0] two,
                                input logic [7:0] start_ticks, input logic [7:0] rep_ticks);
    put_reg(kps_pkg::REG_SHIFT_ONE, one);
    put_reg(kps_pkg::REG_SHIFT_TWO, two);
    put_reg(kps_pkg::REG_REPEAT_START, start_ticks);
    put_reg(kps_pkg::REG_REPEAT, rep_ticks);
    cfg_valid <= 1'b0;
  endtask

  // Hold a key for a number of ticks, with reads and key rolls mixed in, then release
  task automatic hold_key(input int ticks, input int read_pct);
    logic [KEYS-1:0] matrix;
    logic [1:0]      shifts;
    logic [1:0]      up_shifts;
    matrix = KEYS'($urandom_range(1, (1 << KEYS) - 1));
    shifts = 2'($urandom);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 99) < read_pct) read_key();
      if ($urandom_range(0, 19) == 0) matrix = KEYS'($urandom_range(1, (1 << KEYS) - 1));
      if ($urandom_range(0, 19) == 0) shifts = 2'($urandom);
      tick(matrix, shifts);
    end
    repeat ($urandom_range(1, 2)) begin
      up_shifts = 2'($urandom);
      tick('0, up_shifts);
    end
  endtask

  // Mostly well-formed presses, some read bursts and some raw noise
  task automatic random_phase(input int budget, input int read_pct, input int max_hold);
    int              stop;
    logic [KEYS-1:0] matrix;
    logic [1:0]      shifts;
    logic            cmd;
    stop = words_sent + budget;
    while (words_sent < stop) begin
      case ($urandom_range(0, 9))
        0: begin
          cmd    = 1'($urandom);
          matrix = KEYS'($urandom);
          shifts = 2'($urandom);
          send_word(cmd, matrix, shifts);
        end
        1: repeat ($urandom_range(1, 6)) read_key();
        default: hold_key($urandom_range(1, max_hold), read_pct);
      endcase
    end
  endtask

  // Receiver: stall on a changing pattern, with one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       span;
    m_tready <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 64);
      repeat (span) begin
        @(posedge clk);
        if (hold_req) begin
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= ~m_tready;
        endcase
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("keypad_scanner_with_repeat_top regression: fail");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: register defaults, debounce paths, releases, shift offsets
    send_word(kps_pkg::CMD_READ, 4'hF, 2'd3);
    tick(4'h0, 2'd0);
    tick(4'h1, 2'd0);
    tick(4'h0, 2'd0);
    tick(4'h1, 2'd0);
    tick(4'h1, 2'd0);
    tick(4'h0, 2'd0);
    tick(4'h2, 2'd1);
    tick(4'h0, 2'd0);
    tick(4'h0, 2'd0);
    tick(4'h4, 2'd2);
    tick(4'h4, 2'd2);
    tick(4'h0, 2'd0);
    tick(4'h0, 2'd0);
    tick(4'h8, 2'd3);
    tick(4'h8, 2'd3);
    tick(4'hC, 2'd0);
    tick(4'hF, 2'd3);
    tick(4'h0, 2'd0);
    tick(4'h6, 2'd1);
    tick(4'hA, 2'd2);
    repeat (6) read_key();
    drain_results();

    // Default repeat timing: long holds reach the first and later repeats
    random_phase(80, 30, 70);

    // Zero offsets, repeat on every tick; fill the store and stall the output
    drain_results();
    write_settings(8'd0, 8'd0, 8'd1, 8'd1);
    random_phase(40, 20, 12);
    hold_req = 1'b1;
    steady   = 1'b1;
    repeat (40) tick(4'h2, 2'd3);
    steady   = 1'b0;
    drain_results();

    // Largest offsets wrap the code; repeat disabled
    write_settings(8'd255, 8'd255, 8'd0, 8'd255);
    random_phase(40, 30, 10);

    // Code 255 stored and returned as valid; single repeat only
    drain_results();
    write_settings(8'd252, 8'd0, 8'd2, 8'd0);
    repeat (FIFO_DEPTH + 1) read_key();
    tick(4'h0, 2'd0);
    tick(4'h0, 2'd0);
    tick(4'h8, 2'd1);
    tick(4'h8, 2'd1);
    read_key();
    random_phase(40, 25, 10);

    // Longest wait before the first repeat
    drain_results();
    write_settings(8'd17, 8'd200, 8'd255, 8'd1);
    hold_key(258, 5);

    // Random settings with short repeat timing
    for (int k = 0; k < 4; k++) begin
      drain_results();
      write_settings(8'($urandom), 8'($urandom), 8'($urandom_range(1, 8)),
                     8'($urandom_range(0, 4)));
      random_phase(20, $urandom_range(10, 50), 16);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("keypad_scanner_with_repeat_top regression: pass");
    else
      $display("keypad_scanner_with_repeat_top regression: fail");
    $finish;
  end

endmodule
